FILE: sv/mhtc_pkg.sv
package mhtc_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_SET    = 2'd1,
      CMD_DECODE = 2'd2,
      CMD_ENCODE = 2'd3
   } cmd_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DEC,
      ST_SCAN,
      ST_OUT
   } state_type;

   // Character that marks an unassigned table entry.
   localparam logic [7:0] EMPTY_MARK = 8'h40;

   // Character value that never encodes.
   localparam logic [7:0] NUL_CHAR = 8'h00;

endpackage

FILE: sv/morse_heap_table_codec.sv
// Morse code translation table held as an implicit binary tree in one RAM.
// A code of n symbols (dot 1, dash 0, first symbol highest) sits at heap node
// (1 << n) | pattern, and its character is stored at RAM address node - 1.
// Request channel (req_valid/req_stall) carries a command with a character,
// a code length and a pattern. Response channel (rsp_valid/rsp_stall) returns
// one transfer for decode and encode, none for clear and set.
// Steps per command:
//   set     the RAM is written at the accepting edge.
//   decode  the RAM is read at the accepting edge, ST_DEC then formats the
//           pending result and ST_OUT loads it into the response register.
//   encode  the scan reads one RAM entry per cycle from address 0 and stops
//           at the first match or at the last entry; '@' and NUL skip it.
//   clear   all TABLE_LEN - 1 entries are rewritten to '@', one per cycle.
// The block works on one command at a time and holds req_stall high while busy.
// After reset the same clearing pass runs before the first request transfer
// is taken. A response waits in its output register
// while rsp_stall is high; the block stalls only once the next result is ready
// and the register is still occupied.
module morse_heap_table_codec #(
   parameter int TABLE_LEN    = 128,
   parameter int MAX_CODE_LEN = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_in_char,
   input  logic [2:0] req_in_len,
   input  logic [5:0] req_in_pattern,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic [2:0] rsp_out_len,
   output logic [5:0] rsp_out_pattern,
   output logic       rsp_found
);

   localparam int            DEPTH    = TABLE_LEN - 1;
   localparam int            AW       = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   mhtc_pkg::state_type state_ff, state_in;

   logic [AW-1:0] idx_ff, idx_in;
   logic [3:0]    lvl_ff, lvl_in;
   logic [AW-1:0] mask_ff, mask_in;
   logic [AW-1:0] pat_ff, pat_in;
   logic [7:0]    key_ff, key_in;
   logic          dec_ok_ff, dec_ok_in;

   logic [7:0] pend_char_ff, pend_char_in;
   logic [2:0] pend_len_ff, pend_len_in;
   logic [5:0] pend_pat_ff, pend_pat_in;
   logic       pend_found_ff, pend_found_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic [2:0] rsp_len_ff;
   logic [5:0] rsp_pat_ff;
   logic       rsp_found_ff;

   logic [7:0]    table_mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   logic          accept;
   logic          idx_ok;
   logic [AW-1:0] code_idx;
   logic          hit;
   logic          last;
   logic          rsp_free;
   logic          rsp_load;
   logic          skip_encode;
   logic [15:0]   pat_ext;

   // Code length and pattern to table address.
   mhtc_node_calc #(
      .TABLE_LEN    (TABLE_LEN),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_node_calc (
      .code_len     (req_in_len),
      .code_pattern (req_in_pattern),
      .idx_ok       (idx_ok),
      .code_idx     (code_idx)
   );

   // Handshake and scan status.
   assign req_stall   = (state_ff != mhtc_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign hit         = (rd_data_ff == key_ff);
   assign last        = (idx_ff == LAST_IDX);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == mhtc_pkg::ST_OUT) && rsp_free;
   assign skip_encode = (req_in_char == mhtc_pkg::EMPTY_MARK) ||
                        (req_in_char == mhtc_pkg::NUL_CHAR);
   assign pat_ext     = 16'(pat_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhtc_pkg::ST_CLEAR: begin
            if (last) begin
               state_in = mhtc_pkg::ST_IDLE;
            end
         end
         mhtc_pkg::ST_IDLE: begin
            if (accept) begin
               case (mhtc_pkg::cmd_type'(req_cmd))
                  mhtc_pkg::CMD_CLEAR:  state_in = mhtc_pkg::ST_CLEAR;
                  mhtc_pkg::CMD_SET:    state_in = mhtc_pkg::ST_IDLE;
                  mhtc_pkg::CMD_DECODE: state_in = mhtc_pkg::ST_DEC;
                  mhtc_pkg::CMD_ENCODE: begin
                     state_in = skip_encode ? mhtc_pkg::ST_OUT : mhtc_pkg::ST_SCAN;
                  end
                  default: state_in = mhtc_pkg::ST_IDLE;
               endcase
            end
         end
         mhtc_pkg::ST_DEC: begin
            state_in = mhtc_pkg::ST_OUT;
         end
         mhtc_pkg::ST_SCAN: begin
            if (hit || last) begin
               state_in = mhtc_pkg::ST_OUT;
            end
         end
         mhtc_pkg::ST_OUT: begin
            if (rsp_free) begin
               state_in = mhtc_pkg::ST_IDLE;
            end
         end
         default: state_in = mhtc_pkg::ST_IDLE;
      endcase
   end

   // RAM ports, scan counters and the pending result.
   always_comb begin
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      mask_in       = mask_ff;
      pat_in        = pat_ff;
      key_in        = key_ff;
      dec_ok_in     = dec_ok_ff;
      pend_char_in  = pend_char_ff;
      pend_len_in   = pend_len_ff;
      pend_pat_in   = pend_pat_ff;
      pend_found_in = pend_found_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = mhtc_pkg::EMPTY_MARK;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;
      case (state_ff)
         mhtc_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + AW'(1);
         end
         mhtc_pkg::ST_IDLE: begin
            if (accept) begin
               case (mhtc_pkg::cmd_type'(req_cmd))
                  mhtc_pkg::CMD_CLEAR: begin
                     idx_in = '0;
                  end
                  mhtc_pkg::CMD_SET: begin
                     mem_we    = idx_ok;
                     mem_waddr = code_idx;
                     mem_wdata = req_in_char;
                  end
                  mhtc_pkg::CMD_DECODE: begin
                     mem_re    = idx_ok;
                     mem_raddr = code_idx;
                     dec_ok_in = idx_ok;
                  end
                  mhtc_pkg::CMD_ENCODE: begin
                     // Start at the root: address 0 is node 1, level 0.
                     key_in        = req_in_char;
                     idx_in        = '0;
                     lvl_in        = 4'd0;
                     mask_in       = '0;
                     pat_in        = '0;
                     mem_re        = !skip_encode;
                     mem_raddr     = '0;
                     pend_char_in  = 8'd0;
                     pend_len_in   = 3'd0;
                     pend_pat_in   = 6'd0;
                     pend_found_in = 1'b0;
                  end
                  default: begin
                     idx_in = idx_ff;
                  end
               endcase
            end
         end
         mhtc_pkg::ST_DEC: begin
            pend_char_in  = dec_ok_ff ? rd_data_ff : mhtc_pkg::EMPTY_MARK;
            pend_len_in   = 3'd0;
            pend_pat_in   = 6'd0;
            pend_found_in = 1'b1;
         end
         mhtc_pkg::ST_SCAN: begin
            if (hit) begin
               pend_len_in   = lvl_ff[2:0];
               pend_pat_in   = pat_ext[5:0];
               pend_found_in = 1'b1;
            end else if (!last) begin
               // Read the next address and step the node to level and pattern.
               idx_in    = idx_ff + AW'(1);
               mem_re    = 1'b1;
               mem_raddr = idx_ff + AW'(1);
               if (pat_ff == mask_ff) begin
                  pat_in  = '0;
                  mask_in = {mask_ff[AW-2:0], 1'b1};
                  lvl_in  = lvl_ff + 4'd1;
               end else begin
                  pat_in = pat_ff + AW'(1);
               end
            end
         end
         mhtc_pkg::ST_OUT: begin
            idx_in = idx_ff;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhtc_pkg::ST_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Scan and pending result registers.
   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      mask_ff       <= mask_in;
      pat_ff        <= pat_in;
      key_ff        <= key_in;
      dec_ok_ff     <= dec_ok_in;
      pend_char_ff  <= pend_char_in;
      pend_len_ff   <= pend_len_in;
      pend_pat_ff   <= pend_pat_in;
      pend_found_ff <= pend_found_in;
   end

   // Table RAM with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_char_ff  <= pend_char_ff;
         rsp_len_ff   <= pend_len_ff;
         rsp_pat_ff   <= pend_pat_ff;
         rsp_found_ff <= pend_found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_out_len     = rsp_len_ff;
   assign rsp_out_pattern = rsp_pat_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

FILE: sv/mhtc_node_calc.sv
module mhtc_node_calc #(
   parameter int TABLE_LEN    = 128,
   parameter int MAX_CODE_LEN = 6
) (
   input  logic [2:0]                          code_len,
   input  logic [5:0]                          code_pattern,
   output logic                                idx_ok,
   output logic [$clog2(TABLE_LEN - 1) - 1:0]  code_idx
);

   localparam int         DEPTH     = TABLE_LEN - 1;
   localparam int         AW        = $clog2(DEPTH);
   localparam logic [11:0] DEPTH_W  = 12'(DEPTH);
   localparam logic [3:0] MAX_LEN_W = 4'(MAX_CODE_LEN);

   logic [7:0]  lead_bit;
   logic [7:0]  low_mask;
   logic [7:0]  node;
   logic [7:0]  node_m1;
   logic [11:0] node_m1_ext;

   // Heap node: a leading one above the low code_len bits of the pattern.
   always_comb begin
      lead_bit    = 8'd1 << code_len;
      low_mask    = lead_bit - 8'd1;
      node        = lead_bit | ({2'b00, code_pattern} & low_mask);
      node_m1     = node - 8'd1;
      node_m1_ext = {4'b0000, node_m1};
   end

   // The code is usable only if it is short enough and its node lies in the table.
   assign idx_ok   = ({1'b0, code_len} <= MAX_LEN_W) && (node_m1_ext < DEPTH_W);
   assign code_idx = node_m1_ext[AW-1:0];

endmodule

FILE: sv/mhtc_checker.sv
module mhtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic [2:0] rsp_out_len,
   input logic [5:0] rsp_out_pattern,
   input logic       rsp_found
);

   // The clearing pass after reset holds off request transfers.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during the clearing pass after reset");

   // A stalled response stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
         $stable(rsp_out_len) && $stable(rsp_out_pattern) && $stable(rsp_found))
      else $error("stalled response changed");

   // A failed encode carries an empty code.
   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_out_len == 3'd0 && rsp_out_pattern == 6'd0 &&
         rsp_out_char == 8'd0)
      else $error("encode miss with a non-empty code");

   // A response with a character is a decode and carries no code.
   a_decode_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char != 8'd0 |-> rsp_found && rsp_out_len == 3'd0 &&
         rsp_out_pattern == 6'd0)
      else $error("decode response carries a code");

endmodule

bind morse_heap_table_codec mhtc_checker u_mhtc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_char    (rsp_out_char),
   .rsp_out_len     (rsp_out_len),
   .rsp_out_pattern (rsp_out_pattern),
   .rsp_found       (rsp_found)
);
